[rtl/core/bf5_pkg.sv]
// bf5_pkg: shared widths, types and constants of the 5-tap box filter
// used by every module under rtl/core; depends on nothing
package bf5_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int TAPS         = 5;
	localparam int HIST_DEPTH   = 4;

	// stream bus data width, sample padded up to whole bytes
	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// sum of five samples, and its magnitude (at most 5 * 2^(w-1))
	localparam int SUM_W = SAMPLE_WIDTH + 3;
	localparam int MAG_W = SAMPLE_WIDTH + 2;

	// divide by five as multiply by ceil(2^k / 5) and shift by k
	localparam int RECIP_SHIFT = SAMPLE_WIDTH + 5;
	localparam int RECIP_W     = SAMPLE_WIDTH + 3;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) / 64'd5) + 64'd1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	typedef logic [SAMPLE_WIDTH-1:0]  samp_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [DATA_W-1:0]        tdata_t;
	typedef logic [1:0]               cnt_t;

	// one window handed from the sequencer to the adder
	typedef struct packed {
		logic [TAPS-1:0][SAMPLE_WIDTH-1:0] taps;
		logic                              fin;
	} win_t;

	// window sum split into sign and magnitude for the divider
	typedef struct packed {
		mag_t mag;
		logic neg;
		logic fin;
	} part_t;

endpackage

[rtl/core/box_filter_5tap_edge_clamp_unit.sv]
// box_filter_5tap_edge_clamp_unit: centered 5-tap box filter, replicate padding
// top level; instantiates bf5_front, bf5_sum and bf5_div5, uses bf5_pkg
//
//   channel   signals                      contents
//   s_*       tvalid tready tdata tlast    sample in, tlast marks frame end
//   m_*       tvalid tready tdata tlast    smoothed out, tlast on final output
//
// one sample per cycle unless stalled; output i leaves after sample i+2 arrives,
// through three register stages (sequencer, adder, divider/output register).
// a sample flagged tlast yields one to three outputs, one per cycle unless stalled,
// and the sequencer holds off the next sample until its last output moves on.
// stalls on m_tready back up through the stages; reset clears history and valids.
module box_filter_5tap_edge_clamp_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  bf5_pkg::tdata_t       s_tdata,   // [15:0] sample
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output bf5_pkg::tdata_t       m_tdata,   // [15:0] smoothed
	output logic                  m_tlast
);

	bf5_pkg::win_t  win;
	logic           win_valid;
	logic           win_ready;
	bf5_pkg::part_t part;
	logic           part_valid;
	logic           part_ready;
	bf5_pkg::samp_t smoothed;

	bf5_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[bf5_pkg::SAMPLE_WIDTH-1:0]),
		.in_last   (s_tlast),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win)
	);

	bf5_sum u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win_ready  (win_ready),
		.win        (win),
		.part_valid (part_valid),
		.part_ready (part_ready),
		.part       (part)
	);

	bf5_div5 u_div5 (
		.clk        (clk),
		.arst_n     (arst_n),
		.part_valid (part_valid),
		.part_ready (part_ready),
		.part       (part),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.smoothed   (smoothed),
		.last_res   (m_tlast)
	);

	assign m_tdata = bf5_pkg::tdata_t'(smoothed);

endmodule

[rtl/core/bf5_front.sv]
// bf5_front: sample history, per-frame count and window sequencer
// holds one accepted item and hands out its zero to three windows; uses bf5_pkg
module bf5_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bf5_pkg::samp_t       in_sample,
	input  logic                 in_last,
	output logic                 win_valid,
	input  logic                 win_ready,
	output bf5_pkg::win_t        win
);

	logic [bf5_pkg::HIST_DEPTH-1:0][bf5_pkg::SAMPLE_WIDTH-1:0] history_q;
	logic [bf5_pkg::HIST_DEPTH-1:0][bf5_pkg::SAMPLE_WIDTH-1:0] hist_eff;
	bf5_pkg::cnt_t seen_q;

	logic [bf5_pkg::HIST_DEPTH-1:0][bf5_pkg::SAMPLE_WIDTH-1:0] hist_s1;
	bf5_pkg::samp_t x_s1;
	logic           last_s1;
	logic           valid_s1;
	bf5_pkg::cnt_t  start_s1;
	bf5_pkg::cnt_t  rem_s1;

	logic          accept;
	logic          advance;
	bf5_pkg::cnt_t n_new;
	bf5_pkg::cnt_t start_new;

	assign advance  = valid_s1 && win_ready;
	assign in_ready = !valid_s1 || (win_ready && rem_s1 == 2'd1);
	assign accept   = in_valid && in_ready;

	// first sample of a frame pads the start
	always_comb begin
		for (int k = 0; k < bf5_pkg::HIST_DEPTH; k++) begin
			hist_eff[k] = (seen_q == 2'd0) ? in_sample : history_q[k];
		end
	end

	always_comb begin
		if (in_last) begin
			unique case (seen_q)
				2'd0:    n_new = 2'd1;
				2'd1:    n_new = 2'd2;
				default: n_new = 2'd3;
			endcase
			start_new = 2'd3 - n_new;
		end else begin
			n_new     = (seen_q == 2'd2) ? 2'd1 : 2'd0;
			start_new = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			seen_q    <= 2'd0;
		end else if (accept) begin
			if (in_last) begin
				history_q <= '0;
				seen_q    <= 2'd0;
			end else begin
				for (int k = 0; k < bf5_pkg::HIST_DEPTH - 1; k++) begin
					history_q[k] <= hist_eff[k+1];
				end
				history_q[bf5_pkg::HIST_DEPTH-1] <= in_sample;
				if (seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (n_new != 2'd0);
		end else if (advance) begin
			valid_s1 <= (rem_s1 != 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_s1  <= hist_eff;
			x_s1     <= in_sample;
			last_s1  <= in_last;
			start_s1 <= start_new;
			rem_s1   <= n_new;
		end else if (advance) begin
			start_s1 <= start_s1 + 2'd1;
			rem_s1   <= rem_s1 - 2'd1;
		end
	end

	// positions past the history read the current sample (end padding)
	always_comb begin
		logic [2:0] idx;
		idx = 3'd0;
		for (int j = 0; j < bf5_pkg::TAPS; j++) begin
			idx = {1'b0, start_s1} + 3'(j);
			win.taps[j] = (idx < 3'd4) ? hist_s1[idx[1:0]] : x_s1;
		end
		win.fin = last_s1 && (rem_s1 == 2'd1);
	end

	assign win_valid = valid_s1;

endmodule

[rtl/core/bf5_sum.sv]
// bf5_sum: adds the five taps of a window and splits sign and magnitude
// pipeline stage two of the filter; uses bf5_pkg
module bf5_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 win_valid,
	output logic                 win_ready,
	input  bf5_pkg::win_t        win,
	output logic                 part_valid,
	input  logic                 part_ready,
	output bf5_pkg::part_t       part
);

	logic           valid_s2;
	bf5_pkg::part_t part_s2;
	bf5_pkg::part_t part_d;
	bf5_pkg::sum_t  sum;

	always_comb begin
		sum = '0;
		for (int j = 0; j < bf5_pkg::TAPS; j++) begin
			sum = sum + bf5_pkg::sum_t'($signed(win.taps[j]));
		end
		part_d.neg = sum[bf5_pkg::SUM_W-1];
		part_d.mag = part_d.neg ? bf5_pkg::mag_t'(-sum) : bf5_pkg::mag_t'(sum);
		part_d.fin = win.fin;
	end

	assign win_ready = !valid_s2 || part_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (win_ready) begin
			valid_s2 <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win_ready && win_valid) begin
			part_s2 <= part_d;
		end
	end

	assign part_valid = valid_s2;
	assign part       = part_s2;

endmodule

[rtl/core/bf5_div5.sv]
// bf5_div5: divides the window magnitude by five and restores the sign
// reciprocal multiply into the output register; uses bf5_pkg
module bf5_div5 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 part_valid,
	output logic                 part_ready,
	input  bf5_pkg::part_t       part,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bf5_pkg::samp_t       smoothed,
	output logic                 last_res
);

	logic           valid_q;
	bf5_pkg::samp_t smoothed_q;
	logic           last_q;
	bf5_pkg::prod_t prod;
	bf5_pkg::samp_t quot;
	bf5_pkg::samp_t smoothed_d;

	// exact floor(mag / 5) over the whole magnitude range
	assign prod       = bf5_pkg::prod_t'(part.mag) * bf5_pkg::prod_t'(bf5_pkg::RECIP);
	assign quot       = prod[bf5_pkg::RECIP_SHIFT +: bf5_pkg::SAMPLE_WIDTH];
	assign smoothed_d = part.neg ? (~quot + 1'b1) : quot;

	assign part_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (part_ready) begin
			valid_q <= part_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (part_ready && part_valid) begin
			smoothed_q <= smoothed_d;
			last_q     <= part.fin;
		end
	end

	assign out_valid = valid_q;
	assign smoothed  = smoothed_q;
	assign last_res  = last_q;

endmodule

[rtl/core/bf5_checker.sv]
// bf5_checker: port-level assertions for the box filter top level
// bound to box_filter_5tap_edge_clamp_unit; uses bf5_pkg
module bf5_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic            s_tlast,
	input logic            m_tvalid,
	input logic            m_tready,
	input bf5_pkg::tdata_t m_tdata,
	input logic            m_tlast
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] seen_q;
	logic [3:0] pending_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// samples of the current frame seen so far, saturating at two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
		end else if (in_acc) begin
			if (s_tlast) begin
				seen_q <= 2'd0;
			end else if (seen_q != 2'd2) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	// samples taken whose outputs have not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + {3'd0, in_acc} - {3'd0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tlast && seen_q != 2'd0 |=> !s_tready)
		else $error("input taken during a multi-output flush");

	a_no_extra_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 4'd0)
		else $error("more outputs than samples");

	a_valid_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 4'd0)
		else $error("output offered with no sample outstanding");

endmodule

bind box_filter_5tap_edge_clamp_unit bf5_checker u_bf5_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[sim/box_filter_5tap_edge_clamp_unit_tb.sv]
// box_filter_5tap_edge_clamp_unit_tb: self-checking bench for the 5-tap box filter
// drives framed samples on s_*, predicts smoothed outputs, checks m_*; uses bf5_pkg
// needs only the rtl/core sources, no files or arguments
module box_filter_5tap_edge_clamp_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W         = bf5_pkg::SAMPLE_WIDTH;
	localparam int SMAX      = 2 ** (W - 1) - 1;
	localparam int SMIN      = -(2 ** (W - 1));
	localparam int N_RANDOM  = 135;
	localparam int CALM_TAIL = 30;     // random items at the end sent with no idling
	localparam int HOLD_CYC  = 40;
	localparam int LIMIT     = 200000;
	localparam int DRAIN     = 12;

	typedef logic signed [W-1:0] ssamp_t;

	typedef struct {
		ssamp_t smoothed;
		logic   fin;
	} avg_out_t;

	typedef struct {
		ssamp_t sample;
		bit     last;
		bit     lit;       // expected outputs all equal lit_val
		ssamp_t lit_val;
	} dir_row_t;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	bf5_pkg::tdata_t s_tdata;
	logic            s_tlast;
	logic            m_tvalid;
	logic            m_tready;
	bf5_pkg::tdata_t m_tdata;
	logic            m_tlast;

	// predictor state
	ssamp_t          hist [4];
	bf5_pkg::cnt_t   seen;
	avg_out_t        avg_q [$];

	int       err_cnt;
	int       cycle_cnt;
	int       n_samples;
	int       n_frames;
	int       n_checked;
	int       n_in_stall;
	bit       idle_on;
	bit       hold_req;

	dir_row_t dir_tab [25] = '{
		'{ssamp_t'(SMAX),   1'b1, 1'b1, ssamp_t'(SMAX)},
		'{ssamp_t'(SMIN),   1'b1, 1'b1, ssamp_t'(SMIN)},
		'{ssamp_t'(0),      1'b1, 1'b1, ssamp_t'(0)},
		'{ssamp_t'(-1),     1'b1, 1'b1, ssamp_t'(-1)},
		'{ssamp_t'(100),    1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(100),    1'b1, 1'b1, ssamp_t'(100)},
		'{ssamp_t'(SMIN),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMIN),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMIN),   1'b1, 1'b1, ssamp_t'(SMIN)},
		'{ssamp_t'(SMAX),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMIN),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMAX),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMIN),   1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(1),      1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(-3),     1'b1, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(-1),     1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(-2),     1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(0),      1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(0),      1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(0),      1'b1, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(12345),  1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(-54),    1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(7),      1'b0, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(SMAX),   1'b1, 1'b0, ssamp_t'(0)},
		'{ssamp_t'(-21846), 1'b1, 1'b1, ssamp_t'(-21846)}
	};

	box_filter_5tap_edge_clamp_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// queues the smoothed outputs one accepted sample causes, returns their count
	function automatic int smooth_sample(ssamp_t x, logic fin);
		int w [7];
		int n;
		int k;
		int j;
		int sum;
		avg_out_t r;
		if (seen == 0) begin
			for (k = 0; k < 4; k++)
				hist[k] = x;
		end
		for (k = 0; k < 4; k++)
			w[k] = hist[k];
		for (k = 4; k < 7; k++)
			w[k] = x;
		n = 0;
		if (!fin) begin
			if (seen >= 2) begin
				sum = w[0] + w[1] + w[2] + w[3] + w[4];
				r.smoothed = ssamp_t'(sum / 5);
				r.fin = 1'b0;
				avg_q.insert(avg_q.size(), r);
				n = 1;
			end
			for (k = 0; k < 3; k++)
				hist[k] = hist[k + 1];
			hist[3] = x;
			if (seen < 2)
				seen = seen + 2'd1;
		end else begin
			// end padding: flush windows ending at the last sample repeated
			n = (seen + 1 > 3) ? 3 : seen + 1;
			for (k = 0; k < n; k++) begin
				sum = 0;
				for (j = 0; j < 5; j++)
					sum += w[3 - n + k + j];
				r.smoothed = ssamp_t'(sum / 5);
				r.fin = (k == n - 1);
				avg_q.insert(avg_q.size(), r);
			end
			for (k = 0; k < 4; k++)
				hist[k] = '0;
			seen = '0;
		end
		return n;
	endfunction

	// offers one sample, optionally after an idle burst, and waits for the handshake
	task automatic send_sample(ssamp_t x, bit last, bit lit, ssamp_t lit_val);
		int n;
		int k;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= bf5_pkg::tdata_t'(x);
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		n = smooth_sample(x, last);
		if (lit) begin
			for (k = avg_q.size() - n; k < avg_q.size(); k++)
				avg_q[k].smoothed = lit_val;
		end
		n_samples++;
		if (last)
			n_frames++;
	endtask

	// receiver side: random stall bursts, one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		avg_out_t e;
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				n_in_stall++;
			if (m_tvalid && m_tready) begin
				if (avg_q.size() == 0) begin
					$error("unexpected output smoothed=%0d last=%0b",
						$signed(m_tdata[W-1:0]), m_tlast);
					err_cnt++;
				end else begin
					e = avg_q.pop_front();
					n_checked++;
					if (m_tdata[W-1:0] !== e.smoothed) begin
						$error("smoothed: expected %0d, actual %0d", e.smoothed,
							$signed(m_tdata[W-1:0]));
						err_cnt++;
					end
					if (m_tlast !== e.fin) begin
						$error("last_res: expected %0b, actual %0b", e.fin, m_tlast);
						err_cnt++;
					end
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= LIMIT) begin
				$display("timeout after %0d cycles, %0d outputs pending", cycle_cnt,
					avg_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int k;
		int len;
		int sent;
		int pick;
		ssamp_t x;
		err_cnt    = 0;
		n_samples  = 0;
		n_frames   = 0;
		n_checked  = 0;
		n_in_stall = 0;
		hold_req   = 1'b0;
		idle_on    = 1'b1;
		seen       = '0;
		for (k = 0; k < 4; k++)
			hist[k] = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_tab); i++)
			send_sample(dir_tab[i].sample, dir_tab[i].last, dir_tab[i].lit,
				dir_tab[i].lit_val);

		// random frames, mostly short, some long enough to stream steadily
		sent = 0;
		while (sent < N_RANDOM) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 8);
			else if (pick < 9)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(25, 40);
			if (len > N_RANDOM - sent)
				len = N_RANDOM - sent;
			for (k = 0; k < len; k++) begin
				if (sent == 60)
					hold_req = 1'b1;
				if (N_RANDOM - sent <= CALM_TAIL)
					idle_on = 1'b0;
				case ($urandom_range(0, 9))
					0:       x = ssamp_t'(SMAX);
					1:       x = ssamp_t'(SMIN);
					2, 3:    x = ssamp_t'($urandom_range(0, 20) - 10);
					default: x = ssamp_t'($urandom);
				endcase
				send_sample(x, k == len - 1, 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (avg_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d samples in %0d frames, checked %0d smoothed outputs",
			n_samples, n_frames, n_checked);
		$display("receiver hold-off of %0d cycles, input stalled %0d cycles",
			HOLD_CYC, n_in_stall);
		if (err_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
